>>> rtl/vcc_pkg.sv
// shared types, codes and constants of the vertex component converter
package vcc_pkg;

  // working width of an exact magnitude and of its binary exponent
  localparam int XW = 48;
  localparam int KW = 10;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SRC = 2'd0,
    CFG_DST = 2'd1,
    CFG_NRM = 2'd2
  } cfg_idx_e;

  // source type codes
  localparam logic [2:0] SRC_I8  = 3'd0;
  localparam logic [2:0] SRC_U8  = 3'd1;
  localparam logic [2:0] SRC_I16 = 3'd2;
  localparam logic [2:0] SRC_U16 = 3'd3;
  localparam logic [2:0] SRC_U32 = 3'd4;
  localparam logic [2:0] SRC_F32 = 3'd5;

  // destination type codes
  localparam logic [2:0] DST_I8  = 3'd0;
  localparam logic [2:0] DST_U8  = 3'd1;
  localparam logic [2:0] DST_I16 = 3'd2;
  localparam logic [2:0] DST_U16 = 3'd3;
  localparam logic [2:0] DST_I32 = 3'd4;
  localparam logic [2:0] DST_U32 = 3'd5;
  localparam logic [2:0] DST_F32 = 3'd6;

  // significands of 1/255 and 1/65535 in single precision (2/x shares them)
  localparam logic [23:0] MANT_INV255   = 24'h808081;
  localparam logic [23:0] MANT_INV65535 = 24'h800080;

  // exponent of the least significant product bit for each scale
  localparam logic signed [KW-1:0] K_TWO255   = -KW'(30);
  localparam logic signed [KW-1:0] K_ONE255   = -KW'(31);
  localparam logic signed [KW-1:0] K_TWO65535 = -KW'(38);
  localparam logic signed [KW-1:0] K_ONE65535 = -KW'(39);
  localparam logic signed [KW-1:0] K_ONE_U32  = -KW'(32);

  // bias terms 1/255 and 1/65535 as single-precision words
  localparam logic [31:0] F_BIAS8  = 32'h3B808081;
  localparam logic [31:0] F_BIAS16 = 32'h37800080;

  // wrap a 32-bit integer into the destination type and extend it
  function automatic logic [31:0] wrap_dest(logic [31:0] u, logic [2:0] dt);
    logic [31:0] r;
    case (dt)
      DST_I8:  r = {{24{u[7]}}, u[7:0]};
      DST_U8:  r = {24'h0, u[7:0]};
      DST_I16: r = {{16{u[15]}}, u[15:0]};
      DST_U16: r = {16'h0, u[15:0]};
      default: r = u;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/vcc_norm_round.sv
// two-stage normalise and round-to-nearest-even unit for single precision
module vcc_norm_round import vcc_pkg::*; #(
  parameter int W = XW
) (
  input  logic                 clk_i,
  input  logic                 ld_a_i,
  input  logic                 ld_b_i,
  input  logic [W-1:0]         x_i,
  input  logic signed [KW-1:0] k_i,
  input  logic                 sign_i,
  output logic [31:0]          f_o
);

  localparam int LZW = $clog2(W);

  logic [LZW-1:0]       lz;
  logic [W-1:0]         xn_d, xn_q;
  logic signed [KW-1:0] e_d, e_q;
  logic                 s_q, z_q;
  logic [24:0]          m25;
  logic                 g, sticky, up;
  logic [7:0]           e8;
  logic [31:0]          f_d, f_q;

  // leading zero count and left shift
  always_comb begin
    lz = '0;
    for (int i = 0; i < W; i++) begin
      if (x_i[i]) lz = LZW'(W - 1 - i);
    end
    xn_d = x_i << lz;
    e_d  = k_i + KW'(W + 126) - KW'(lz);
  end

  always_ff @(posedge clk_i) begin
    if (ld_a_i) begin
      xn_q <= xn_d;
      e_q  <= e_d;
      s_q  <= sign_i;
      z_q  <= (x_i == '0);
    end
  end

  // round to 24 significant bits, ties to even
  always_comb begin
    g      = xn_q[W-25];
    sticky = |xn_q[W-26:0];
    up     = g && (sticky || xn_q[W-24]);
    m25    = {1'b0, xn_q[W-1 -: 24]} + 25'(up);
    e8     = e_q[7:0] + 8'(m25[24]);
    f_d    = z_q ? 32'h0 : {s_q, e8, (m25[24] ? 23'h0 : m25[22:0])};
  end

  always_ff @(posedge clk_i) begin
    if (ld_b_i) f_q <= f_d;
  end

  assign f_o = f_q;

endmodule

>>> rtl/vertex_component_converter.sv
// Vertex component converter: takes one raw attribute component per beat and
// returns it in the configured destination type. Eight register stages
// (capture, decode and scale multiply, normalise, round, bias add, normalise,
// round, output) give a rate of one beat per cycle; a beat waits only while
// the output register holds a stalled result and the stages behind it are
// full. Write source_type, dest_type and normalize only while no beat is in
// flight; each beat takes the settings present when it enters.
module vertex_component_converter import vcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] raw_component_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] converted_value_o
);

  localparam int NS = 8;

  logic [2:0] src_q, dst_q;
  logic       nrm_q;
  logic [NS-1:0] v_q, v_d, ld;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= SRC_I8;
      dst_q <= DST_F32;
      nrm_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SRC: src_q <= cfg_data_i;
        CFG_DST: dst_q <= cfg_data_i;
        CFG_NRM: nrm_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage load enables, a stage loads when empty or when it drains
  always_comb begin
    ld[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !v_q[i] || ld[i+1];
    end
    v_d[0] = ld[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < NS; i++) begin
      v_d[i] = ld[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= v_d;
  end

  assign in_stall_o = !ld[0];

  // stage 1: capture beat and settings
  logic [31:0] raw1_q;
  logic [2:0]  st1_q, dt1_q;
  logic        nrm1_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      raw1_q <= raw_component_i;
      st1_q  <= src_q;
      dt1_q  <= dst_q;
      nrm1_q <= nrm_q;
    end
  end

  // float to integer: truncate, saturate, nan gives zero
  function automatic logic [31:0] f2i(logic [31:0] f, logic [2:0] dt);
    logic [7:0]  e;
    logic [31:0] sig, m, hi, lomag, r;
    logic        nan, huge;
    e    = f[30:23];
    sig  = {8'h0, 1'b1, f[22:0]};
    nan  = (e == 8'hFF) && (f[22:0] != 23'h0);
    huge = (e >= 8'd159);
    if (e < 8'd127)       m = 32'h0;
    else if (e <= 8'd150) m = sig >> (8'd150 - e);
    else                  m = sig << (e - 8'd150);
    case (dt)
      DST_I8:  begin hi = 32'd127;        lomag = 32'd128;        end
      DST_U8:  begin hi = 32'd255;        lomag = 32'd0;          end
      DST_I16: begin hi = 32'd32767;      lomag = 32'd32768;      end
      DST_U16: begin hi = 32'd65535;      lomag = 32'd0;          end
      DST_I32: begin hi = 32'h7FFF_FFFF;  lomag = 32'h8000_0000;  end
      default: begin hi = 32'hFFFF_FFFF;  lomag = 32'd0;          end
    endcase
    if (nan)                    r = 32'h0;
    else if (!f[31])            r = (huge || m > hi) ? hi : m;
    else                        r = (huge || m > lomag) ? -lomag : -m;
    return wrap_dest(r, dt);
  endfunction

  // stage 2: decode source, scale multiply, integer results
  logic [31:0]          sx, mag, dir2_d;
  logic                 sgn2_d, fp2_d, scale;
  logic [23:0]          cm;
  logic [39:0]          prod;
  logic [XW-1:0]        x2_d, x2_q;
  logic signed [KW-1:0] k2_d, k2_q;
  logic [31:0]          bias2_d, bias2_q, dir2_q;
  logic                 sgn2_q, fp2_q;

  always_comb begin
    case (st1_q)
      SRC_I8:  sx = {{24{raw1_q[7]}}, raw1_q[7:0]};
      SRC_U8:  sx = {24'h0, raw1_q[7:0]};
      SRC_I16: sx = {{16{raw1_q[15]}}, raw1_q[15:0]};
      SRC_U16: sx = {16'h0, raw1_q[15:0]};
      default: sx = raw1_q;
    endcase
    sgn2_d = (st1_q == SRC_I8 || st1_q == SRC_I16) && sx[31];
    mag    = sgn2_d ? -sx : sx;
    fp2_d  = (st1_q <= SRC_U32) && (dt1_q == DST_F32);
    scale  = fp2_d && nrm1_q;
    cm     = (st1_q == SRC_I8 || st1_q == SRC_U8) ? MANT_INV255 : MANT_INV65535;
    prod   = 40'(mag[15:0]) * 40'(cm);
    x2_d    = XW'(mag);
    k2_d    = '0;
    bias2_d = 32'h0;
    if (scale) begin
      case (st1_q)
        SRC_I8:  begin x2_d = XW'(prod); k2_d = K_TWO255;   bias2_d = F_BIAS8;  end
        SRC_U8:  begin x2_d = XW'(prod); k2_d = K_ONE255;                        end
        SRC_I16: begin x2_d = XW'(prod); k2_d = K_TWO65535; bias2_d = F_BIAS16; end
        SRC_U16: begin x2_d = XW'(prod); k2_d = K_ONE65535;                      end
        default: k2_d = K_ONE_U32;
      endcase
    end
    if (st1_q > SRC_F32 || dt1_q > DST_F32) dir2_d = 32'h0;
    else if (st1_q == SRC_F32)               dir2_d = (dt1_q == DST_F32) ? raw1_q
                                                      : f2i(raw1_q, dt1_q);
    else                                     dir2_d = wrap_dest(sx, dt1_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      x2_q    <= x2_d;
      k2_q    <= k2_d;
      sgn2_q  <= sgn2_d;
      bias2_q <= bias2_d;
      fp2_q   <= fp2_d;
      dir2_q  <= dir2_d;
    end
  end

  // stages 3 and 4: round the scaled value
  logic [31:0] fa;

  vcc_norm_round #(.W(XW)) u_round_mul (
    .clk_i  (clk_i),
    .ld_a_i (ld[2]),
    .ld_b_i (ld[3]),
    .x_i    (x2_q),
    .k_i    (k2_q),
    .sign_i (sgn2_q),
    .f_o    (fa)
  );

  logic [31:0] bias3_q, bias4_q, dir3_q, dir4_q;
  logic        fp3_q, fp4_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      bias3_q <= bias2_q;
      fp3_q   <= fp2_q;
      dir3_q  <= dir2_q;
    end
    if (ld[3]) begin
      bias4_q <= bias3_q;
      fp4_q   <= fp3_q;
      dir4_q  <= dir3_q;
    end
  end

  // stage 5: align and add the bias exactly
  logic                 za, zb;
  logic [7:0]           ea, eb, d;
  logic [XW-1:0]        a_al, b_al, x5_d, x5_q;
  logic signed [KW-1:0] k5_d, k5_q;
  logic                 s5_d, s5_q, fp5_q;
  logic [31:0]          dir5_q;

  always_comb begin
    za   = (fa[30:0] == 31'h0);
    zb   = (bias4_q[30:0] == 31'h0);
    ea   = fa[30:23];
    eb   = bias4_q[30:23];
    d    = (ea - eb > 8'd24) ? 8'd24 : ea - eb;
    a_al = XW'({1'b1, fa[22:0]}) << d;
    b_al = XW'({1'b1, bias4_q[22:0]});
    if (zb) begin
      x5_d = za ? '0 : XW'({1'b1, fa[22:0]});
      k5_d = $signed(KW'(ea)) - KW'(150);
      s5_d = fa[31] && !za;
    end else if (za) begin
      x5_d = b_al;
      k5_d = $signed(KW'(eb)) - KW'(150);
      s5_d = bias4_q[31];
    end else begin
      x5_d = (fa[31] == bias4_q[31]) ? a_al + b_al : a_al - b_al;
      k5_d = $signed(KW'(eb)) - KW'(150);
      s5_d = fa[31];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      x5_q   <= x5_d;
      k5_q   <= k5_d;
      s5_q   <= s5_d;
      fp5_q  <= fp4_q;
      dir5_q <= dir4_q;
    end
  end

  // stages 6 and 7: round the sum
  logic [31:0] fs;

  vcc_norm_round #(.W(XW)) u_round_add (
    .clk_i  (clk_i),
    .ld_a_i (ld[5]),
    .ld_b_i (ld[6]),
    .x_i    (x5_q),
    .k_i    (k5_q),
    .sign_i (s5_q),
    .f_o    (fs)
  );

  logic [31:0] dir6_q, dir7_q;
  logic        fp6_q, fp7_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      fp6_q  <= fp5_q;
      dir6_q <= dir5_q;
    end
    if (ld[6]) begin
      fp7_q  <= fp6_q;
      dir7_q <= dir6_q;
    end
  end

  // stage 8: output register
  logic [31:0] out_q;

  always_ff @(posedge clk_i) begin
    if (ld[7]) out_q <= fp7_q ? fs : dir7_q;
  end

  assign out_valid_o       = v_q[NS-1];
  assign converted_value_o = out_q;

endmodule

>>> rtl/vcc_checker.sv
// port-level checks for the vertex component converter and their binding
module vcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] converted_value_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(converted_value_o))
    else $error("stalled result beat changed");

  // input waits only behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a full pipeline stays full while the output keeps stalling
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o ##1 out_stall_i |-> in_stall_o)
    else $error("full pipeline lost a beat under output stall");

  // configuration writes are never refused
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind vertex_component_converter vcc_checker u_vcc_checker (.*);
